// File: rtl/sfd_pkg.sv
// sfd_pkg: shared types and constants of the serial frame decoder
// used by sfd_front, sfd_queue, sfd_back and sbus_frame_decoder_top
package sfd_pkg;

	localparam int FRAME_STORE   = 24;
	localparam int POS_W         = 5;
	localparam int MEM_AW        = POS_W + 1;
	localparam int CH_W          = 11;
	localparam int NUM_CH        = 16;
	localparam int CH_IDX_W      = 4;
	localparam int VAL_W         = 12;

	localparam logic [POS_W-1:0] POS_HDR       = 5'd0;
	localparam logic [POS_W-1:0] POS_FIRST_CH  = 5'd1;
	localparam logic [POS_W-1:0] POS_FLAGS     = 5'd23;
	localparam logic [POS_W-1:0] POS_FOOT      = 5'd24;
	localparam logic [POS_W-1:0] POS_MAX       = 5'd31;

	localparam logic [7:0] HDR_A   = 8'h0F;
	localparam logic [7:0] HDR_B   = 8'h8F;
	localparam logic [7:0] FTR_A   = 8'h00;
	localparam logic [7:0] FTR_B   = 8'h08;
	localparam logic [7:0] FS_MASK = 8'h0C;

	localparam logic [10:0] IN_OFFSET_RST  = 11'd256;
	localparam logic [16:0] GAIN_RST       = 17'd44492;
	localparam logic [11:0] OUT_OFFSET_RST = 12'd1000;
	localparam logic [11:0] VAL_MAX        = 12'hFFF;

	localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_LOST = 2'd1,
		STAT_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_IN_OFFSET  = 2'd0,
		REG_GAIN       = 2'd1,
		REG_OUT_OFFSET = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		status_t status;
		logic    bank;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

// File: rtl/sfd_front.sv
// sfd_front: takes frame bytes, tracks position, writes the byte store,
// checks header, flags and footer; depends on sfd_pkg
module sfd_front import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // frame_start
	output wr_t        wr,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       q_full,
	input  rel_t       rel
);

	logic [POS_W-1:0] pos_q;
	logic             wbank_q;
	logic [1:0]       busy_q;
	logic             hdr_ok_q;
	logic             fs_q;

	logic [POS_W-1:0] pos;
	logic             accept;
	logic             ftr_ok;
	status_t          stat;

	assign pos      = s_tuser ? POS_HDR : pos_q;
	assign s_tready = !busy_q[wbank_q] && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign ftr_ok   = (s_tdata == FTR_A) || (s_tdata == FTR_B);

	always_comb begin
		if (!(hdr_ok_q && ftr_ok))
			stat = STAT_BAD;
		else if (fs_q)
			stat = STAT_LOST;
		else
			stat = STAT_OK;
	end

	assign wr.en           = accept && (pos < POS_W'(FRAME_STORE));
	assign wr.addr         = {wbank_q, pos};
	assign wr.data         = s_tdata;
	assign push            = accept && (pos == POS_FOOT);
	assign push_cmd.status = stat;
	assign push_cmd.bank   = wbank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			wbank_q  <= 1'b0;
			busy_q   <= '0;
			hdr_ok_q <= 1'b0;
			fs_q     <= 1'b0;
		end else begin
			if (rel.valid)
				busy_q[rel.bank] <= 1'b0;
			if (accept) begin
				pos_q <= (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
				if (pos == POS_HDR)
					hdr_ok_q <= (s_tdata == HDR_A) || (s_tdata == HDR_B);
				if (pos == POS_FLAGS)
					fs_q <= |(s_tdata & FS_MASK);
				if (pos == POS_FOOT && stat == STAT_OK) begin
					busy_q[wbank_q] <= 1'b1;
					wbank_q         <= !wbank_q;
				end
			end
		end
	end

endmodule

// File: rtl/sfd_queue.sv
// sfd_queue: two-entry command queue between front and back
// depends on sfd_pkg
module sfd_queue import sfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head  = ent_q[rp_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/sfd_back.sv
// sfd_back: byte store, bit unpacker, channel scaling and result register
// holds the configuration registers; depends on sfd_pkg
module sfd_back import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  wr_t         wr,
	input  cmd_t        head,
	input  logic        empty,
	output logic        pop,
	output rel_t        rel,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // channel_index, channel_value, status
	output logic        m_tlast   // last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACC,
		S_MUL,
		S_OUT
	} state_t;

	localparam int ACC_W  = CH_W + 7;
	localparam int FILL_W = 5;

	logic [7:0]        mem [2**MEM_AW];
	logic [7:0]        rdata_q;

	logic [10:0]       in_offset_q;
	logic [16:0]       gain_q;
	logic [11:0]       out_offset_q;

	state_t            state_q;
	logic              bank_q;
	logic [POS_W-1:0]  addr_q;
	logic [ACC_W-1:0]  acc_q;
	logic [FILL_W-1:0] fill_q;
	logic              pend_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic signed [11:0] diff_q;
	logic signed [29:0] prod_q;

	logic              m_valid_q;
	logic [CH_IDX_W-1:0] m_idx_q;
	logic [VAL_W-1:0]  m_val_q;
	status_t           m_stat_q;
	logic              m_last_q;

	logic              out_free;
	logic              rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic [ACC_W-1:0]  acc_sum;
	logic [FILL_W-1:0] fill_sum;
	logic signed [13:0] scaled;
	logic signed [14:0] sum;
	logic [VAL_W-1:0]  sat_val;
	logic signed [17:0] gain_s;

	assign out_free = !m_valid_q || m_tready;
	assign acc_sum  = pend_q ? (acc_q | (ACC_W'(rdata_q) << fill_q)) : acc_q;
	assign fill_sum = pend_q ? fill_q + FILL_W'(8) : fill_q;
	assign scaled   = prod_q[29:16];
	assign sum      = {scaled[13], scaled} + $signed({3'b000, out_offset_q});
	assign gain_s   = $signed({1'b0, gain_q});

	always_comb begin
		if (sum < 0)
			sat_val = '0;
		else if (sum > $signed({3'b000, VAL_MAX}))
			sat_val = VAL_MAX;
		else
			sat_val = sum[VAL_W-1:0];
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {bank_q, addr_q};
		pop     = 1'b0;
		case (state_q)
			S_IDLE: begin
				rd_addr = {head.bank, POS_FIRST_CH};
				if (!empty) begin
					if (head.status == STAT_OK) begin
						rd_en = 1'b1;
						pop   = 1'b1;
					end else begin
						pop = out_free;
					end
				end
			end
			S_ACC:   rd_en = (fill_sum < FILL_W'(CH_W));
			S_OUT:   rd_en = out_free && (ch_q != LAST_CH) && (fill_q < FILL_W'(CH_W));
			default: rd_en = 1'b0;
		endcase
	end

	assign rel.valid = (state_q == S_OUT) && out_free && (ch_q == LAST_CH);
	assign rel.bank  = bank_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_offset_q  <= IN_OFFSET_RST;
			gain_q       <= GAIN_RST;
			out_offset_q <= OUT_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_OFFSET:  in_offset_q  <= cfg_data[10:0];
				REG_GAIN:       gain_q       <= cfg_data;
				REG_OUT_OFFSET: out_offset_q <= cfg_data[11:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.status == STAT_OK) begin
							bank_q  <= head.bank;
							addr_q  <= POS_FIRST_CH + 1'b1;
							acc_q   <= '0;
							fill_q  <= '0;
							pend_q  <= 1'b1;
							ch_q    <= '0;
							state_q <= S_ACC;
						end else begin
							m_valid_q <= 1'b1;
							m_idx_q   <= '0;
							m_val_q   <= '0;
							m_stat_q  <= head.status;
							m_last_q  <= 1'b1;
						end
					end
				end
				S_ACC: begin
					if (fill_sum >= FILL_W'(CH_W)) begin
						diff_q  <= $signed({1'b0, acc_sum[CH_W-1:0]})
							- $signed({1'b0, in_offset_q});
						acc_q   <= acc_sum >> CH_W;
						fill_q  <= fill_sum - FILL_W'(CH_W);
						pend_q  <= 1'b0;
						state_q <= S_MUL;
					end else begin
						acc_q  <= acc_sum;
						fill_q <= fill_sum;
						pend_q <= 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				S_MUL: begin
					prod_q  <= diff_q * gain_s;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_idx_q   <= ch_q;
						m_val_q   <= sat_val;
						m_stat_q  <= STAT_OK;
						m_last_q  <= (ch_q == LAST_CH);
						if (ch_q == LAST_CH) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							pend_q  <= rd_en;
							state_q <= S_ACC;
							if (rd_en)
								addr_q <= addr_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b000000, m_stat_q, m_val_q, m_idx_q};
	assign m_tlast  = m_last_q;

endmodule

// File: rtl/sbus_frame_decoder_top.sv
// sbus_frame_decoder_top: serial radio frame decoder, sixteen scaled channels
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
//
// channel  dir  signals                          content
// s_       in   s_tvalid s_tready s_tdata s_tuser  one frame byte, start flag
// m_       out  m_tvalid m_tready m_tdata m_tlast  channel or status result
// cfg_     in   cfg_we cfg_index cfg_data          in_offset, gain_q16, out_offset
//
// the front takes one byte a cycle; it stalls only while both store banks
// wait for unpacking or the two-entry command queue is full
// the back registers a status-only result straight from idle; a good frame
// is done channel by channel through the accumulate, multiply and output steps,
// paced by the one-byte-a-cycle store read port and the multiply stage
// no clearing pass after reset; a full output register stalls the back only
module sbus_frame_decoder_top import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // channel_index, channel_value, status
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	wr_t  wr;
	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic q_full;
	logic q_empty;
	rel_t rel;

	sfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.wr       (wr),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full),
		.rel      (rel)
	);

	sfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	sfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.rel       (rel),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
